/* rtl/command_frame_receiver_top_defines.svh */
`ifndef COMMAND_FRAME_RECEIVER_TOP_DEFINES_SVH
`define COMMAND_FRAME_RECEIVER_TOP_DEFINES_SVH

// same-cycle implication, checked on every clock while out of reset
`define CFR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on every clock while out of reset
`define CFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/cfr_pkg.sv */
package cfr_pkg;

	// register file geometry
	localparam int AddrWidth = 5;
	localparam int DataWidth = 32;

	// frame layout constants
	localparam logic [7:0] MinLength      = 8'd11;
	localparam logic [7:0] IdBytes        = 8'd8;
	localparam logic [7:0] CheckedIdCount = 8'd4;

	// configuration reset values
	localparam logic [7:0] HeaderReset   = 8'd170;
	localparam logic [7:0] TrailerReset  = 8'd14;
	localparam logic [7:0] SequenceReset = 8'd0;
	localparam logic [7:0] SourceReset   = 8'd0;
	localparam logic [7:0] DestBaseReset = 8'd1;
	localparam logic [7:0] DestLockReset = 8'd2;
	localparam logic [7:0] BaseIdReset   = 8'd0;
	localparam logic [7:0] CommandReset  = 8'd0;

	// register indexes
	typedef enum logic [2:0] {
		REG_HEADER    = 3'd0,
		REG_TRAILER   = 3'd1,
		REG_SEQUENCE  = 3'd2,
		REG_SOURCE    = 3'd3,
		REG_DEST_BASE = 3'd4,
		REG_DEST_LOCK = 3'd5,
		REG_BASE_ID   = 3'd6,
		REG_COMMAND   = 3'd7
	} cfr_reg_t;

	// frame status codes
	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_HEADER      = 4'd1,
		ST_COMMAND     = 4'd2,
		ST_LENGTH      = 4'd3,
		ST_SEQUENCE    = 4'd4,
		ST_SOURCE      = 4'd5,
		ST_DESTINATION = 4'd6,
		ST_CHECKSUM    = 4'd7,
		ST_TRAILER     = 4'd8
	} cfr_status_t;

	// parser phases
	typedef enum logic [3:0] {
		PH_HUNT  = 4'd0,
		PH_HDR2  = 4'd1,
		PH_CMD   = 4'd2,
		PH_LEN   = 4'd3,
		PH_SEQ   = 4'd4,
		PH_SRC   = 4'd5,
		PH_DEST  = 4'd6,
		PH_ID    = 4'd7,
		PH_DATA  = 4'd8,
		PH_LRC   = 4'd9,
		PH_TRAIL = 4'd10
	} cfr_phase_t;

	// compare results worked out per byte in the front part
	typedef struct packed {
		logic hdr;
		logic trl;
		logic seq;
		logic src;
		logic base;
		logic lock;
		logic bid;
		logic cmd;
		logic short_len;
	} cfr_class_t;

	// one queued byte with its classification
	typedef struct packed {
		logic [7:0] data;
		cfr_class_t cls;
	} cfr_item_t;

endpackage

/* rtl/cfr_front.sv */
module cfr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cfr_pkg::AddrWidth-1:0] paddr,
	input  logic [cfr_pkg::DataWidth-1:0] pwdata,
	output logic [cfr_pkg::DataWidth-1:0] prdata,
	input  logic [7:0]                    rx_byte,
	output cfr_pkg::cfr_item_t            item
);
	import cfr_pkg::*;

	logic [7:0] header_q, trailer_q, sequence_q, source_q;
	logic [7:0] dest_base_q, dest_lock_q, base_id_q, command_q;
	logic [7:0] rd_val;
	cfr_reg_t   reg_idx;

	assign reg_idx = cfr_reg_t'(paddr[AddrWidth-1:2]);

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q    <= HeaderReset;
			trailer_q   <= TrailerReset;
			sequence_q  <= SequenceReset;
			source_q    <= SourceReset;
			dest_base_q <= DestBaseReset;
			dest_lock_q <= DestLockReset;
			base_id_q   <= BaseIdReset;
			command_q   <= CommandReset;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_HEADER:    header_q    <= pwdata[7:0];
				REG_TRAILER:   trailer_q   <= pwdata[7:0];
				REG_SEQUENCE:  sequence_q  <= pwdata[7:0];
				REG_SOURCE:    source_q    <= pwdata[7:0];
				REG_DEST_BASE: dest_base_q <= pwdata[7:0];
				REG_DEST_LOCK: dest_lock_q <= pwdata[7:0];
				REG_BASE_ID:   base_id_q   <= pwdata[7:0];
				REG_COMMAND:   command_q   <= pwdata[7:0];
				default:       header_q    <= header_q;
			endcase
		end
	end

	// register read mux
	always_comb begin
		unique case (reg_idx)
			REG_HEADER:    rd_val = header_q;
			REG_TRAILER:   rd_val = trailer_q;
			REG_SEQUENCE:  rd_val = sequence_q;
			REG_SOURCE:    rd_val = source_q;
			REG_DEST_BASE: rd_val = dest_base_q;
			REG_DEST_LOCK: rd_val = dest_lock_q;
			REG_BASE_ID:   rd_val = base_id_q;
			REG_COMMAND:   rd_val = command_q;
			default:       rd_val = 8'd0;
		endcase
	end

	assign prdata = {{(DataWidth-8){1'b0}}, rd_val};

	// classify the incoming byte against every configured value
	always_comb begin
		item.data          = rx_byte;
		item.cls.hdr       = (rx_byte == header_q);
		item.cls.trl       = (rx_byte == trailer_q);
		item.cls.seq       = (rx_byte == sequence_q);
		item.cls.src       = (rx_byte == source_q);
		item.cls.base      = (rx_byte == dest_base_q);
		item.cls.lock      = (rx_byte == dest_lock_q);
		item.cls.bid       = (rx_byte == base_id_q);
		item.cls.cmd       = (rx_byte == command_q);
		item.cls.short_len = (rx_byte < MinLength);
	end

endmodule

/* rtl/cfr_queue.sv */
module cfr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  cfr_pkg::cfr_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output cfr_pkg::cfr_item_t pop_item
);
	import cfr_pkg::*;

	cfr_item_t  entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop)      count_q <= count_q + 2'd1;
			else if (!do_push && do_pop) count_q <= count_q - 2'd1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_item;
	end

endmodule

/* rtl/cfr_back.sv */
module cfr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  cfr_pkg::cfr_item_t item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               kind,
	output logic [7:0]         payload_byte,
	output logic [3:0]         status,
	output logic [7:0]         command,
	output logic [7:0]         sequence_res,
	output logic               dest_is_lock,
	output logic [63:0]        device_id
);
	import cfr_pkg::*;

	cfr_phase_t  phase_q, phase_d;
	logic [7:0]  lrc_q, lrc_d, cmd_q, cmd_d, seq_q, seq_d;
	logic [7:0]  plen_q, plen_d, cnt_q, cnt_d, cnt_inc;
	logic        dest_q, dest_d, herr_q, herr_d;
	logic [63:0] id_q, id_d;
	logic        fin, res;
	cfr_status_t fin_st;
	logic        pop;
	logic [7:0]  b;
	cfr_class_t  c;

	logic        valid_q, kind_q, dest_out_q;
	logic [7:0]  pay_q, cmd_out_q, seq_out_q;
	logic [3:0]  st_q;
	logic [63:0] id_out_q;

	assign b          = item.data;
	assign c          = item.cls;
	assign item_ready = !valid_q || out_ready;
	assign pop        = item_valid && item_ready;
	assign cnt_inc    = cnt_q + 8'd1;

	// parser next state
	always_comb begin
		phase_d = phase_q;
		lrc_d   = lrc_q;
		cmd_d   = cmd_q;
		seq_d   = seq_q;
		plen_d  = plen_q;
		cnt_d   = cnt_q;
		dest_d  = dest_q;
		herr_d  = herr_q;
		id_d    = id_q;
		fin     = 1'b0;
		fin_st  = ST_OK;
		res     = 1'b0;
		unique case (phase_q)
			PH_HDR2: begin
				cmd_d   = 8'd0;
				seq_d   = 8'd0;
				plen_d  = 8'd0;
				dest_d  = 1'b0;
				id_d    = 64'd0;
				cnt_d   = 8'd0;
				lrc_d   = 8'd0;
				herr_d  = !c.hdr;
				phase_d = PH_CMD;
			end
			PH_CMD: begin
				cmd_d = b;
				if (herr_q) begin
					fin    = 1'b1;
					fin_st = ST_HEADER;
				end else if (!c.cmd) begin
					fin    = 1'b1;
					fin_st = ST_COMMAND;
				end else begin
					lrc_d   = b;
					phase_d = PH_LEN;
				end
			end
			PH_LEN: begin
				if (c.short_len) begin
					fin    = 1'b1;
					fin_st = ST_LENGTH;
				end else begin
					plen_d  = b - MinLength;
					lrc_d   = lrc_q ^ b;
					phase_d = PH_SEQ;
				end
			end
			PH_SEQ: begin
				if (!c.seq) begin
					fin    = 1'b1;
					fin_st = ST_SEQUENCE;
				end else begin
					seq_d   = b;
					lrc_d   = lrc_q ^ b;
					phase_d = PH_SRC;
				end
			end
			PH_SRC: begin
				if (!c.src) begin
					fin    = 1'b1;
					fin_st = ST_SOURCE;
				end else begin
					lrc_d   = lrc_q ^ b;
					phase_d = PH_DEST;
				end
			end
			PH_DEST: begin
				if (c.base || c.lock) begin
					// base wins when both codes match
					dest_d  = !c.base;
					lrc_d   = lrc_q ^ b;
					cnt_d   = 8'd0;
					phase_d = PH_ID;
				end else begin
					fin    = 1'b1;
					fin_st = ST_DESTINATION;
				end
			end
			PH_ID: begin
				for (int i = 0; i < 8; i++) begin
					if (cnt_q[2:0] == 3'(i)) id_d[8*i +: 8] = id_q[8*i +: 8] | b;
				end
				lrc_d = lrc_q ^ b;
				cnt_d = cnt_inc;
				if (cnt_inc == CheckedIdCount) begin
					if (!c.bid) begin
						fin    = 1'b1;
						fin_st = ST_DESTINATION;
					end
				end else if (cnt_inc >= IdBytes) begin
					cnt_d   = 8'd0;
					phase_d = (plen_q == 8'd0) ? PH_LRC : PH_DATA;
				end
			end
			PH_DATA: begin
				lrc_d = lrc_q ^ b;
				cnt_d = cnt_inc;
				res   = 1'b1;
				if (cnt_inc >= plen_q) begin
					cnt_d   = 8'd0;
					phase_d = PH_LRC;
				end
			end
			PH_LRC: begin
				if (b != lrc_q) begin
					fin    = 1'b1;
					fin_st = ST_CHECKSUM;
				end else begin
					phase_d = PH_TRAIL;
				end
			end
			PH_TRAIL: begin
				fin    = 1'b1;
				fin_st = c.trl ? ST_OK : ST_TRAILER;
			end
			default: begin
				phase_d = c.hdr ? PH_HDR2 : PH_HUNT;
			end
		endcase
		// end of frame returns to hunting
		if (fin) begin
			res     = 1'b1;
			phase_d = PH_HUNT;
			herr_d  = 1'b0;
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			herr_q  <= 1'b0;
			lrc_q   <= 8'd0;
			cmd_q   <= 8'd0;
			seq_q   <= 8'd0;
			plen_q  <= 8'd0;
			cnt_q   <= 8'd0;
			dest_q  <= 1'b0;
			id_q    <= 64'd0;
		end else if (pop) begin
			phase_q <= phase_d;
			herr_q  <= herr_d;
			lrc_q   <= lrc_d;
			cmd_q   <= cmd_d;
			seq_q   <= seq_d;
			plen_q  <= plen_d;
			cnt_q   <= cnt_d;
			dest_q  <= dest_d;
			id_q    <= id_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop && res) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (pop && res) begin
			kind_q     <= fin;
			pay_q      <= fin ? 8'd0 : b;
			st_q       <= fin_st;
			cmd_out_q  <= cmd_d;
			seq_out_q  <= seq_d;
			dest_out_q <= dest_d;
			id_out_q   <= id_d;
		end
	end

	assign out_valid    = valid_q;
	assign kind         = kind_q;
	assign payload_byte = pay_q;
	assign status       = st_q;
	assign command      = cmd_out_q;
	assign sequence_res = seq_out_q;
	assign dest_is_lock = dest_out_q;
	assign device_id    = id_out_q;

endmodule

/* rtl/command_frame_receiver_top.sv */
// Command frame receiver: takes one received byte per transaction and parses
// header, command, length, sequence, source, destination, eight ID bytes,
// payload, XOR checksum and trailer. Each payload byte comes out as a result
// of kind 0 and every frame ends with one kind 1 result carrying its status.
// Bytes are taken one per clock while the queue has room: the front compares
// each byte against the configured values and pushes it into a two-entry
// queue, and the parser pops one byte per clock whenever its output register
// is empty or being taken. Configuration registers sit on the APB port at
// byte addresses 4*i and take no wait states. The user must write them only
// while no frame is in flight; the block itself does not enforce this.
module command_frame_receiver_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cfr_pkg::AddrWidth-1:0] paddr,
	input  logic [cfr_pkg::DataWidth-1:0] pwdata,
	output logic [cfr_pkg::DataWidth-1:0] prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          kind,
	output logic [7:0]                    payload_byte,
	output logic [3:0]                    status,
	output logic [7:0]                    command,
	output logic [7:0]                    sequence_res,
	output logic                          dest_is_lock,
	output logic [63:0]                   device_id
);
	import cfr_pkg::*;

	cfr_item_t front_item, queue_item;
	logic      queue_valid, queue_ready;

	assign pready = 1'b1;

	// configuration and byte classification
	cfr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.rx_byte (rx_byte),
		.item    (front_item)
	);

	// decoupling queue
	cfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_item  (front_item),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_item   (queue_item)
	);

	// frame parser and output register
	cfr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (queue_valid),
		.item_ready   (queue_ready),
		.item         (queue_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.payload_byte (payload_byte),
		.status       (status),
		.command      (command),
		.sequence_res (sequence_res),
		.dest_is_lock (dest_is_lock),
		.device_id    (device_id)
	);

endmodule

/* rtl/cfr_checker.sv */
`include "command_frame_receiver_top_defines.svh"

module cfr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          kind,
	input logic [7:0]                    payload_byte,
	input logic [3:0]                    status,
	input logic [7:0]                    command,
	input logic [63:0]                   device_id
);
	import cfr_pkg::*;

	// result fields watched while a result waits
	logic [84:0] result_bits;

	assign result_bits = {kind, payload_byte, status, command, device_id};

	// a stalled result holds
	`CFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_bits), "stalled result changed")

	// payload results always carry ok status
	`CFR_ASSERT_NOW(a_pay_status, out_valid && !kind, status == ST_OK, "payload result with status")

	// end-of-frame results carry a zero payload byte
	`CFR_ASSERT_NOW(a_end_payload, out_valid && kind, payload_byte == 8'd0, "status result with payload")

	// status stays within the defined codes
	`CFR_ASSERT_NOW(a_status_range, out_valid, status <= ST_TRAILER, "undefined status code")

	// configuration port never inserts wait states
	`CFR_ASSERT_NOW(a_pready_high, 1'b1, pready, "apb port stalled")

endmodule

bind command_frame_receiver_top cfr_checker u_cfr_checker (.*);

/* test/command_frame_receiver_top_tb.sv */
`timescale 1ns / 1ps

module command_frame_receiver_top_tb;
	import cfr_pkg::*;

	localparam int WatchdogLimit = 4000;
	localparam int SettleCycles  = 8;
	localparam int MaxReports    = 10;

	// which stage of a generated frame gets a wrong byte
	typedef enum int {
		FAULT_NONE,
		FAULT_HEADER,
		FAULT_COMMAND,
		FAULT_LENGTH,
		FAULT_SEQUENCE,
		FAULT_SOURCE,
		FAULT_DEST,
		FAULT_ID,
		FAULT_CHECKSUM,
		FAULT_TRAILER
	} frame_fault_t;

	typedef enum int {
		SET_ZEROS,
		SET_ONES,
		SET_RANDOM
	} reg_setting_t;

	// one frame receiver result, laid out in port order
	typedef struct packed {
		logic        kind;
		logic [7:0]  pay;
		logic [3:0]  status;
		logic [7:0]  cmd;
		logic [7:0]  seq;
		logic        lock;
		logic [63:0] id;
	} frame_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [AddrWidth-1:0] paddr;
	logic [DataWidth-1:0] pwdata;
	logic [DataWidth-1:0] prdata;
	logic                 pready;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           rx_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic                 kind;
	logic [7:0]           payload_byte;
	logic [3:0]           status;
	logic [7:0]           command;
	logic [7:0]           sequence_res;
	logic                 dest_is_lock;
	logic [63:0]          device_id;

	command_frame_receiver_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.payload_byte (payload_byte),
		.status       (status),
		.command      (command),
		.sequence_res (sequence_res),
		.dest_is_lock (dest_is_lock),
		.device_id    (device_id)
	);

	// byte stream waiting to be sent and results waiting to be seen
	logic [7:0]    rx_stream[$];
	frame_result_t expected_results[$];

	int  send_idle_pct;
	int  recv_idle_pct;
	bit  in_taken;
	int  idle_cycles;
	int  mismatches;
	int  bytes_in;
	int  payloads_seen;
	int  frame_ends;
	int  frames_good;
	int  settings_used;

	// parser model: configuration and state
	logic [7:0]  reg_value [8];
	cfr_phase_t  parse_phase;
	logic [7:0]  lrc;
	logic [7:0]  cmd_q;
	logic [7:0]  len_q;
	logic [7:0]  seq_q;
	logic        lock_q;
	logic [63:0] id_q;
	logic [7:0]  count_q;
	logic        hdr_bad;

	// clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// advance the parser model by one byte; returns 1 when a result comes out
	function automatic bit parse_byte(input logic [7:0] b, output frame_result_t r);
		bit          ends;
		bit          emits_payload;
		cfr_status_t st;
		logic [7:0]  payload_len;
		ends = 1'b0;
		emits_payload = 1'b0;
		st = ST_OK;
		r = '0;
		case (parse_phase)
			PH_HDR2: begin
				cmd_q = '0;
				len_q = '0;
				seq_q = '0;
				lock_q = 1'b0;
				id_q = '0;
				count_q = '0;
				lrc = '0;
				hdr_bad = (b != reg_value[REG_HEADER]);
				parse_phase = PH_CMD;
			end
			PH_CMD: begin
				cmd_q = b;
				// a bad second header byte is reported here, command unchecked
				if (hdr_bad) begin
					ends = 1'b1;
					st = ST_HEADER;
				end else if (b != reg_value[REG_COMMAND]) begin
					ends = 1'b1;
					st = ST_COMMAND;
				end else begin
					lrc = b;
					parse_phase = PH_LEN;
				end
			end
			PH_LEN: begin
				if (b < MinLength) begin
					ends = 1'b1;
					st = ST_LENGTH;
				end else begin
					len_q = b;
					lrc ^= b;
					parse_phase = PH_SEQ;
				end
			end
			PH_SEQ: begin
				if (b != reg_value[REG_SEQUENCE]) begin
					ends = 1'b1;
					st = ST_SEQUENCE;
				end else begin
					seq_q = b;
					lrc ^= b;
					parse_phase = PH_SRC;
				end
			end
			PH_SRC: begin
				if (b != reg_value[REG_SOURCE]) begin
					ends = 1'b1;
					st = ST_SOURCE;
				end else begin
					lrc ^= b;
					parse_phase = PH_DEST;
				end
			end
			PH_DEST: begin
				// base wins when both codes are the same
				if (b == reg_value[REG_DEST_BASE]) begin
					lock_q = 1'b0;
				end else if (b == reg_value[REG_DEST_LOCK]) begin
					lock_q = 1'b1;
				end else begin
					ends = 1'b1;
					st = ST_DESTINATION;
				end
				if (!ends) begin
					lrc ^= b;
					count_q = '0;
					parse_phase = PH_ID;
				end
			end
			PH_ID: begin
				id_q |= 64'(b) << (8 * count_q[2:0]);
				lrc ^= b;
				count_q++;
				// only the fourth id byte is checked
				if (count_q == CheckedIdCount) begin
					if (b != reg_value[REG_BASE_ID]) begin
						ends = 1'b1;
						st = ST_DESTINATION;
					end
				end else if (count_q >= IdBytes) begin
					count_q = '0;
					parse_phase = (len_q == MinLength) ? PH_LRC : PH_DATA;
				end
			end
			PH_DATA: begin
				lrc ^= b;
				count_q++;
				emits_payload = 1'b1;
				payload_len = len_q - MinLength;
				if (count_q >= payload_len) begin
					count_q = '0;
					parse_phase = PH_LRC;
				end
			end
			PH_LRC: begin
				if (b != lrc) begin
					ends = 1'b1;
					st = ST_CHECKSUM;
				end else begin
					parse_phase = PH_TRAIL;
				end
			end
			PH_TRAIL: begin
				ends = 1'b1;
				st = (b != reg_value[REG_TRAILER]) ? ST_TRAILER : ST_OK;
			end
			default: begin
				parse_phase = (b == reg_value[REG_HEADER]) ? PH_HDR2 : PH_HUNT;
			end
		endcase
		if (ends) begin
			r = {1'b1, 8'h00, st, cmd_q, seq_q, lock_q, id_q};
			parse_phase = PH_HUNT;
			hdr_bad = 1'b0;
		end else if (emits_payload) begin
			r = {1'b0, b, ST_OK, cmd_q, seq_q, lock_q, id_q};
		end
		return ends || emits_payload;
	endfunction

	// monitor: input transactions feed the model, output transactions are checked
	always @(posedge clk) begin
		frame_result_t want;
		frame_result_t got;
		bit            progress;
		if (arst_n) begin
			progress = 1'b0;
			if (in_valid && in_ready) begin
				if (parse_byte(rx_byte, want))
					expected_results.push_back(want);
				in_taken = 1'b1;
				bytes_in++;
				progress = 1'b1;
			end
			if (out_valid && out_ready) begin
				progress = 1'b1;
				got = {kind, payload_byte, status, command, sequence_res, dest_is_lock,
					device_id};
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MaxReports)
						$display("unexpected result: kind=%0d payload=%h status=%0d",
							got.kind, got.pay, got.status);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= MaxReports) begin
							$display("mismatch: expected kind=%0d payload=%h status=%0d",
								want.kind, want.pay, want.status,
								" cmd=%h seq=%h lock=%0d id=%h",
								want.cmd, want.seq, want.lock, want.id);
							$display("          actual   kind=%0d payload=%h status=%0d",
								got.kind, got.pay, got.status,
								" cmd=%h seq=%h lock=%0d id=%h",
								got.cmd, got.seq, got.lock, got.id);
						end
					end
					if (want.kind) begin
						frame_ends++;
						if (want.status == ST_OK)
							frames_good++;
					end else begin
						payloads_seen++;
					end
				end
			end
			idle_cycles <= progress ? 0 : idle_cycles + 1;
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (idle_cycles >= WatchdogLimit) begin
			$display("watchdog: no transaction for %0d cycles", idle_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// driver: byte stream on the input channel, random stalls on the output
	always @(negedge clk) begin
		bit send;
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				in_taken = 1'b0;
				send = (rx_stream.size() != 0) && ($urandom_range(99) >= send_idle_pct);
				if (send)
					rx_byte <= rx_stream.pop_front();
				in_valid <= send;
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// apb write, model copy updated on the access edge
	task automatic write_reg(input cfr_reg_t idx, input logic [7:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'h0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		reg_value[idx] = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apply_setting(input reg_setting_t setting);
		logic [7:0] value;
		for (int i = 0; i < 8; i++) begin
			case (setting)
				SET_ZEROS: value = 8'h00;
				SET_ONES:  value = 8'hFF;
				default:   value = 8'($urandom_range(255));
			endcase
			write_reg(cfr_reg_t'(i), value);
		end
		settings_used++;
	endtask

	// wait until the stream is sent and every result is in, then let the pipe empty
	task automatic wait_for_drain();
		while (rx_stream.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	// build one frame from the current register values, optionally with one bad byte
	task automatic queue_frame(input frame_fault_t fault, input logic [7:0] len,
			input bit to_lock);
		logic [7:0] frame[$];
		logic [7:0] flip;
		logic [7:0] dest;
		logic [7:0] sum;
		flip = 8'($urandom_range(255, 1));
		dest = to_lock ? reg_value[REG_DEST_LOCK] : reg_value[REG_DEST_BASE];
		if (fault == FAULT_DEST) begin
			dest = 8'($urandom_range(255));
			while (dest == reg_value[REG_DEST_BASE] || dest == reg_value[REG_DEST_LOCK])
				dest = 8'($urandom_range(255));
		end
		frame.push_back(reg_value[REG_HEADER]);
		frame.push_back(reg_value[REG_HEADER] ^ ((fault == FAULT_HEADER) ? flip : 8'h00));
		frame.push_back(reg_value[REG_COMMAND] ^ ((fault == FAULT_COMMAND) ? flip : 8'h00));
		frame.push_back((fault == FAULT_LENGTH) ? 8'($urandom_range(10)) : len);
		frame.push_back(reg_value[REG_SEQUENCE] ^ ((fault == FAULT_SEQUENCE) ? flip : 8'h00));
		frame.push_back(reg_value[REG_SOURCE] ^ ((fault == FAULT_SOURCE) ? flip : 8'h00));
		frame.push_back(dest);
		for (int i = 0; i < 8; i++) begin
			if (i == 3)
				frame.push_back(reg_value[REG_BASE_ID] ^ ((fault == FAULT_ID) ? flip : 8'h00));
			else
				frame.push_back(8'($urandom_range(255)));
		end
		// payload leans toward the byte extremes now and then
		for (int i = MinLength; i < len; i++) begin
			if ($urandom_range(3) == 0)
				frame.push_back($urandom_range(1) ? 8'hFF : 8'h00);
			else
				frame.push_back(8'($urandom_range(255)));
		end
		sum = 8'h00;
		for (int i = 2; i < frame.size(); i++)
			sum ^= frame[i];
		frame.push_back(sum ^ ((fault == FAULT_CHECKSUM) ? flip : 8'h00));
		frame.push_back(reg_value[REG_TRAILER] ^ ((fault == FAULT_TRAILER) ? flip : 8'h00));
		foreach (frame[i])
			rx_stream.push_back(frame[i]);
	endtask

	// mostly good frames with random content, some broken, with line noise between
	task automatic queue_traffic(input int count);
		int           queued;
		frame_fault_t fault;
		logic [7:0]   len;
		logic [7:0]   noise;
		queued = 0;
		while (queued < count) begin
			repeat ($urandom_range(2)) begin
				noise = 8'($urandom_range(255));
				if (noise == reg_value[REG_HEADER] && $urandom_range(7) != 0)
					noise = ~noise;
				rx_stream.push_back(noise);
			end
			if ($urandom_range(99) < 70)
				fault = FAULT_NONE;
			else
				fault = frame_fault_t'($urandom_range(FAULT_TRAILER, FAULT_HEADER));
			case ($urandom_range(19))
				0:       len = 8'($urandom_range(60, 21));
				1, 2, 3: len = MinLength;
				default: len = 8'($urandom_range(20, 12));
			endcase
			queue_frame(fault, len, $urandom_range(1));
			queued += len + 4;
		end
	endtask

	// stimulus and end of run
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		out_ready = 1'b0;
		in_taken = 1'b0;
		idle_cycles = 0;
		mismatches = 0;
		bytes_in = 0;
		payloads_seen = 0;
		frame_ends = 0;
		frames_good = 0;
		settings_used = 1;
		reg_value[REG_HEADER] = HeaderReset;
		reg_value[REG_TRAILER] = TrailerReset;
		reg_value[REG_SEQUENCE] = SequenceReset;
		reg_value[REG_SOURCE] = SourceReset;
		reg_value[REG_DEST_BASE] = DestBaseReset;
		reg_value[REG_DEST_LOCK] = DestLockReset;
		reg_value[REG_BASE_ID] = BaseIdReset;
		reg_value[REG_COMMAND] = CommandReset;
		parse_phase = PH_HUNT;
		lrc = '0;
		cmd_q = '0;
		len_q = '0;
		seq_q = '0;
		lock_q = 1'b0;
		id_q = '0;
		count_q = '0;
		hdr_bad = 1'b0;
		send_idle_pct = 19;
		recv_idle_pct = 71;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed frames at reset values: noise, good frames, one fault per stage
		rx_stream.push_back(8'h00);
		rx_stream.push_back(8'hFF);
		queue_frame(FAULT_NONE, MinLength, 1'b0);
		queue_frame(FAULT_NONE, 8'd13, 1'b1);
		queue_frame(FAULT_HEADER, 8'd12, 1'b0);
		queue_frame(FAULT_COMMAND, 8'd12, 1'b1);
		queue_frame(FAULT_LENGTH, 8'd12, 1'b0);
		queue_frame(FAULT_SEQUENCE, 8'd12, 1'b1);
		queue_frame(FAULT_SOURCE, 8'd12, 1'b0);
		queue_frame(FAULT_DEST, 8'd12, 1'b1);
		queue_frame(FAULT_ID, 8'd12, 1'b0);
		queue_frame(FAULT_CHECKSUM, 8'd12, 1'b1);
		queue_frame(FAULT_TRAILER, MinLength, 1'b0);
		wait_for_drain();

		// all registers zero: equal destination codes, header of zero
		apply_setting(SET_ZEROS);
		queue_traffic(30);
		wait_for_drain();

		// sender mostly idle; the stream is held back once until all results are in
		send_idle_pct = 71;
		recv_idle_pct = 19;
		apply_setting(SET_RANDOM);
		queue_traffic(15);
		wait_for_drain();
		queue_traffic(15);
		wait_for_drain();

		// all registers at their maximum
		apply_setting(SET_ONES);
		queue_traffic(30);
		wait_for_drain();

		// full rate on both sides, including the longest frame
		send_idle_pct = 0;
		recv_idle_pct = 0;
		apply_setting(SET_RANDOM);
		queue_frame(FAULT_NONE, 8'd255, 1'b1);
		queue_traffic(30);
		wait_for_drain();

		$display("sent %0d bytes under %0d register settings", bytes_in, settings_used);
		$display("checked %0d payload bytes and %0d frame ends (%0d good), %0d mismatches",
			payloads_seen, frame_ends, frames_good, mismatches);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
